// ----- hdl/tiled_surface_address_swizzle_assert.svh -----
// ----------------------------------------------------------------------------
// tiled_surface_address_swizzle_assert.svh
// assertion macros for the swizzle rtl; empty under synthesis
// ----------------------------------------------------------------------------
`ifndef TILED_SURFACE_ADDRESS_SWIZZLE_ASSERT_SVH
`define TILED_SURFACE_ADDRESS_SWIZZLE_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every edge outside reset
`define TSS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("tss assertion failed");

// condition must never be true outside reset
`define TSS_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tss forbidden condition seen");

`else

`define TSS_ASSERT(label, clk, rst_n, prop)
`define TSS_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- hdl/tss_pkg.sv -----
// ----------------------------------------------------------------------------
// tss_pkg
// types and constants for the tiled surface address swizzle
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

	localparam int COORD_W    = 16;
	localparam int PITCH_W    = 17;
	localparam int OFFSET_W   = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	// x-major tile: 8 lines of 512 bytes
	localparam int X_LBITS = 3;
	localparam int X_LPOS  = 9;
	// y-major tile: 32 lines of 16 bytes
	localparam int Y_LBITS = 5;
	localparam int Y_LPOS  = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SURFACE_PITCH      = 2'd0,
		REG_TILE_MODE          = 2'd1,
		REG_CHANNEL_XOR_ENABLE = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_LINEAR = 2'd0,
		MODE_X_TILE = 2'd1,
		MODE_Y_TILE = 2'd2
	} tile_mode_t;

	typedef struct packed {
		logic [PITCH_W-1:0] surface_pitch;
		logic [1:0]         tile_mode;
		logic               channel_xor_enable;
	} cfg_t;

endpackage

`default_nettype wire

// ----- hdl/tss_stream_if.sv -----
// ----------------------------------------------------------------------------
// tss_stream_if
// valid/ready channels for coordinates in and offsets out
// ----------------------------------------------------------------------------
`default_nettype none

interface tss_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] byte_column;
	logic [15:0] row_index;

	modport source(output valid, output byte_column, output row_index, input ready);
	modport sink(input valid, input byte_column, input row_index, output ready);
endinterface

interface tss_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] byte_offset;

	modport source(output valid, output byte_offset, input ready);
	modport sink(input valid, input byte_offset, output ready);
endinterface

`default_nettype wire

// ----- hdl/tss_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tss_cfg_regs
// configuration register bank, write only
// ----------------------------------------------------------------------------
`default_nettype none

module tss_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tss_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output tss_pkg::cfg_t                       cfg
);

	tss_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (tss_pkg::cfg_reg_t'(cfg_index))
				tss_pkg::REG_SURFACE_PITCH: begin
					cfg_q.surface_pitch <= cfg_wdata[tss_pkg::PITCH_W-1:0];
				end
				tss_pkg::REG_TILE_MODE: begin
					cfg_q.tile_mode <= cfg_wdata[1:0];
				end
				tss_pkg::REG_CHANNEL_XOR_ENABLE: begin
					cfg_q.channel_xor_enable <= cfg_wdata[0];
				end
				default: begin
					// writes past the register list are dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/tss_addr_calc.sv -----
// ----------------------------------------------------------------------------
// tss_addr_calc
// one multiply-add plus bit placement for linear and tiled layouts
// ----------------------------------------------------------------------------
`default_nettype none

module tss_addr_calc (
	input  wire tss_pkg::cfg_t                 cfg,
	input  wire logic [tss_pkg::COORD_W-1:0]   byte_column,
	input  wire logic [tss_pkg::COORD_W-1:0]   row_index,
	output logic      [tss_pkg::OFFSET_W-1:0]  byte_offset
);

	localparam int PROD_W = tss_pkg::COORD_W + tss_pkg::PITCH_W;

	logic [tss_pkg::COORD_W-1:0]  mul_a;
	logic [tss_pkg::PITCH_W-1:0]  mul_b;
	logic [tss_pkg::COORD_W-1:0]  addend;
	logic [PROD_W-1:0]            prod;
	logic [tss_pkg::OFFSET_W-1:0] sum;
	logic [tss_pkg::OFFSET_W-1:0] off;

	// pick operands so a single multiplier serves all modes
	always_comb begin
		unique case (cfg.tile_mode)
			tss_pkg::MODE_LINEAR: begin
				mul_a  = row_index;
				mul_b  = cfg.surface_pitch;
				addend = byte_column;
			end
			tss_pkg::MODE_Y_TILE: begin
				mul_a  = row_index >> tss_pkg::Y_LBITS;
				mul_b  = cfg.surface_pitch >> tss_pkg::Y_LPOS;
				addend = byte_column >> tss_pkg::Y_LPOS;
			end
			default: begin
				// x-major, also for the unused mode code
				mul_a  = row_index >> tss_pkg::X_LBITS;
				mul_b  = cfg.surface_pitch >> tss_pkg::X_LPOS;
				addend = byte_column >> tss_pkg::X_LPOS;
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign sum  = prod[tss_pkg::OFFSET_W-1:0] + tss_pkg::OFFSET_W'(addend);

	// tile number above line above in-line byte in tiled modes; linear keeps the sum
	always_comb begin
		unique case (cfg.tile_mode)
			tss_pkg::MODE_LINEAR: begin
				off = sum;
			end
			tss_pkg::MODE_Y_TILE: begin
				off = {sum[tss_pkg::OFFSET_W-tss_pkg::Y_LBITS-tss_pkg::Y_LPOS-1:0],
					row_index[tss_pkg::Y_LBITS-1:0],
					byte_column[tss_pkg::Y_LPOS-1:0]};
				if (cfg.channel_xor_enable) begin
					off[6] = off[6] ^ off[9];
				end
			end
			default: begin
				off = {sum[tss_pkg::OFFSET_W-tss_pkg::X_LBITS-tss_pkg::X_LPOS-1:0],
					row_index[tss_pkg::X_LBITS-1:0],
					byte_column[tss_pkg::X_LPOS-1:0]};
				if (cfg.channel_xor_enable) begin
					off[6] = off[6] ^ off[9] ^ off[10];
				end
			end
		endcase
	end

	assign byte_offset = off;

endmodule

`default_nettype wire

// ----- hdl/tiled_surface_address_swizzle.sv -----
// ----------------------------------------------------------------------------
// tiled_surface_address_swizzle
// byte column and row to linear, x-tiled or y-tiled byte offset
// ----------------------------------------------------------------------------
// Takes one coordinate pair per clock and returns one byte offset per clock
// while the output is ready. An accepted pair lands in the input register,
// passes one 16x17 multiply-add and the tile bit placement, and then moves
// into the result register that drives the output. Under output back-pressure
// an empty input register still fills, so the block holds two items before it
// stops accepting; with the output always ready it sustains one item per cycle.
// The user must change configuration only while idle; the block does not enforce it.
`default_nettype none

`include "tiled_surface_address_swizzle_assert.svh"

module tiled_surface_address_swizzle (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tss_pkg::CFG_DATA_W-1:0] cfg_wdata,
	tss_in_if.sink                              in_ch,
	tss_out_if.source                           out_ch
);

	tss_pkg::cfg_t cfg;

	logic                          valid_s1;
	logic [tss_pkg::COORD_W-1:0]   byte_column_s1;
	logic [tss_pkg::COORD_W-1:0]   row_index_s1;
	logic                          valid_s2;
	logic [tss_pkg::OFFSET_W-1:0]  byte_offset_s2;
	logic [tss_pkg::OFFSET_W-1:0]  offset_calc;
	logic                          adv_s2;
	logic                          adv_s1;

	tss_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// result register frees when empty or taken this cycle
	assign adv_s2      = !valid_s2 || out_ch.ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign in_ch.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_ch.valid) begin
			byte_column_s1 <= in_ch.byte_column;
			row_index_s1   <= in_ch.row_index;
		end
	end

	tss_addr_calc u_calc (
		.cfg         (cfg),
		.byte_column (byte_column_s1),
		.row_index   (row_index_s1),
		.byte_offset (offset_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			byte_offset_s2 <= offset_calc;
		end
	end

	assign out_ch.valid       = valid_s2;
	assign out_ch.byte_offset = byte_offset_s2;

	// full pipe with a stalled output must refuse new transactions
	`TSS_ASSERT_NEVER(a_no_accept_when_full, clk, arst_n,
		valid_s1 && valid_s2 && !out_ch.ready && in_ch.ready)

	// an item in the input register reaches the result register when it moves
	`TSS_ASSERT(a_s1_moves_to_s2, clk, arst_n, (valid_s1 && adv_s2) |=> valid_s2)

	// accepted input always occupies the input register next cycle
	`TSS_ASSERT(a_accept_fills_s1, clk, arst_n, (in_ch.valid && in_ch.ready) |=> valid_s1)

	// tiled modes keep the low column nibble in place
	`TSS_ASSERT(a_tiled_low_bits, clk, arst_n,
		(valid_s1 && adv_s2 && cfg.tile_mode != tss_pkg::MODE_LINEAR) |=>
		(byte_offset_s2[3:0] == $past(byte_column_s1[3:0])))

endmodule

`default_nettype wire

// ----- sim/tb_tiled_surface_address_swizzle.sv -----
// ----------------------------------------------------------------------------
// tb_tiled_surface_address_swizzle
// self-checking testbench for the tiled surface address swizzle
// ----------------------------------------------------------------------------
// Sends coordinate pairs under linear, x-tiled, y-tiled and the spare mode
// code, with and without the channel xor and with odd pitches. Each accepted
// pair is turned into an expected offset by a predictor in the scoreboard,
// and offsets leaving the block are compared in order. Both channels idle at
// random, the receiver stalls once for a long stretch to fill the block, and
// the registers are rewritten only once all expected offsets are back.
// ----------------------------------------------------------------------------
module tb_tiled_surface_address_swizzle;
	timeunit 1ns;
	timeprecision 1ps;

	// index with no register behind it; a write there has no effect
	localparam logic [tss_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int MAX_REPORTED = 10;

	class offset_scoreboard;
		logic [tss_pkg::PITCH_W-1:0]  pitch;
		logic [1:0]                   mode;
		logic                         xor_en;
		logic [tss_pkg::OFFSET_W-1:0] pending_offsets[$];
		int                           errors;

		function new();
			pitch = '0;
			mode = tss_pkg::MODE_LINEAR;
			xor_en = 1'b0;
			errors = 0;
		endfunction

		function void write_register(logic [tss_pkg::CFG_IDX_W-1:0] idx,
			logic [tss_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				tss_pkg::REG_SURFACE_PITCH: pitch = data[tss_pkg::PITCH_W-1:0];
				tss_pkg::REG_TILE_MODE: mode = data[1:0];
				tss_pkg::REG_CHANNEL_XOR_ENABLE: xor_en = data[0];
				default: ;
			endcase
		endfunction

		function logic [tss_pkg::OFFSET_W-1:0] predict_offset(logic [15:0] col,
			logic [15:0] row);
			logic [tss_pkg::OFFSET_W-1:0] acc;
			int                           lbits;
			int                           lpos;
			logic                         ymode;
			if (mode == tss_pkg::MODE_LINEAR) begin
				acc = 32'(row) * 32'(pitch) + 32'(col);
				return acc;
			end
			// spare mode code falls back to x-major tiles
			ymode = (mode == tss_pkg::MODE_Y_TILE);
			lbits = ymode ? tss_pkg::Y_LBITS : tss_pkg::X_LBITS;
			lpos = ymode ? tss_pkg::Y_LPOS : tss_pkg::X_LPOS;
			acc = (32'(row) >> lbits) * (32'(pitch) >> lpos) + (32'(col) >> lpos);
			acc = (acc << lbits) + (32'(row) & ((32'd1 << lbits) - 32'd1));
			acc = (acc << lpos) + (32'(col) & ((32'd1 << lpos) - 32'd1));
			if (xor_en)
				acc[6] = acc[6] ^ acc[9] ^ (ymode ? 1'b0 : acc[10]);
			return acc;
		endfunction

		function void note_input(logic [15:0] col, logic [15:0] row);
			pending_offsets.push_back(predict_offset(col, row));
		endfunction

		function void check_result(logic [tss_pkg::OFFSET_W-1:0] got);
			logic [tss_pkg::OFFSET_W-1:0] want;
			if (pending_offsets.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTED)
					$display("%0t: unexpected offset 0x%08h", $realtime, got);
				return;
			end
			want = pending_offsets.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTED)
					$display("%0t: byte_offset expected 0x%08h got 0x%08h",
						$realtime, want, got);
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [tss_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tss_pkg::CFG_DATA_W-1:0] cfg_wdata;

	tss_in_if  in_ch();
	tss_out_if out_ch();

	offset_scoreboard sb;
	int               send_idle_pct;
	int               recv_idle_pct;
	int               stall_ask;

	tiled_surface_address_swizzle u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random back-pressure, plus a long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_ask > 0) begin
				stall_left = stall_ask;
				stall_ask = 0;
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_register(cfg_index, cfg_wdata);
			if (out_ch.valid === 1'b1 && out_ch.ready)
				sb.check_result(out_ch.byte_offset);
			if (in_ch.valid && in_ch.ready === 1'b1)
				sb.note_input(in_ch.byte_column, in_ch.row_index);
		end
	end

	task automatic send_item(input logic [15:0] col, input logic [15:0] row);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.byte_column <= col;
		in_ch.row_index <= row;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
	endtask

	// hold the sender until every expected offset is back
	task automatic drain_offsets();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_offsets.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tss_pkg::CFG_IDX_W-1:0] idx,
		input logic [tss_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic configure(input logic [tss_pkg::CFG_DATA_W-1:0] pitch,
		input logic [tss_pkg::CFG_DATA_W-1:0] mode_word,
		input logic [tss_pkg::CFG_DATA_W-1:0] xor_word);
		drain_offsets();
		write_reg(tss_pkg::REG_SURFACE_PITCH, pitch);
		write_reg(tss_pkg::REG_TILE_MODE, mode_word);
		write_reg(tss_pkg::REG_CHANNEL_XOR_ENABLE, xor_word);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(3))
			0, 1: return 16'($urandom);
			2: return 16'($urandom_range(63));
			default: return ($urandom_range(1) ? 16'hFFFF : 16'h0000) ^
				(16'h1 << $urandom_range(15));
		endcase
	endfunction

	function automatic logic [tss_pkg::CFG_DATA_W-1:0] pick_pitch();
		case ($urandom_range(4))
			0: return 17'($urandom);
			1: return 17'($urandom_range(128)) << tss_pkg::X_LPOS;
			2: return 17'($urandom_range(4096));
			3: return 17'h10000;
			default: return $urandom_range(1) ? 17'h1FFFF : 17'h0;
		endcase
	endfunction

	initial begin
		sb = new();
		send_idle_pct = 16;
		recv_idle_pct = 52;
		stall_ask = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = tss_pkg::REG_SURFACE_PITCH;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.byte_column = '0;
		in_ch.row_index = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at their reset values
		send_item(16'h0000, 16'h0000);
		send_item(16'hFFFF, 16'hFFFF);

		// linear: xor is ignored, largest product wraps
		configure(17'h10000, 17'(tss_pkg::MODE_LINEAR), 17'h1);
		send_item(16'hFFFF, 16'hFFFF);
		send_item(16'h0001, 16'h0002);
		send_item(16'hFFFF, 16'h0000);
		configure(17'h1FFFF, 17'(tss_pkg::MODE_LINEAR), 17'h0);
		send_item(16'hFFFF, 16'hFFFF);
		send_item(16'h0000, 16'hFFFF);

		// x tiles, tile edges
		configure(17'd4096, 17'(tss_pkg::MODE_X_TILE), 17'h0);
		send_item(16'h0000, 16'h0000);
		send_item(16'hFFFF, 16'hFFFF);
		send_item(16'h01FF, 16'h0007);
		send_item(16'h0200, 16'h0008);

		// pitch not a multiple of the tile width, xor folds bits 9 and 10
		configure(17'd1000, 17'(tss_pkg::MODE_X_TILE), 17'h1);
		send_item(16'h03C0, 16'h0013);
		send_item(16'hFFFF, 16'hFFFF);
		send_item(16'h0600, 16'h0009);

		configure(17'd512, 17'(tss_pkg::MODE_Y_TILE), 17'h1);
		send_item(16'h000F, 16'h001F);
		send_item(16'h0010, 16'h0020);
		send_item(16'hFFFF, 16'hFFFF);
		configure(17'h0, 17'(tss_pkg::MODE_Y_TILE), 17'h0);
		send_item(16'd1234, 16'd5678);

		// spare mode code via masked upper bits; xor bit 0 clear then set
		drain_offsets();
		write_reg(tss_pkg::REG_SURFACE_PITCH, 17'd8192);
		write_reg(tss_pkg::REG_TILE_MODE, 17'h1FFFF);
		write_reg(tss_pkg::REG_CHANNEL_XOR_ENABLE, 17'h1FFFE);
		write_reg(tss_pkg::REG_CHANNEL_XOR_ENABLE, 17'h00001);
		write_reg(REG_UNUSED, 17'h1FFFF);
		cfg_we <= 1'b0;
		send_item(16'hFFFF, 16'hFFFF);
		send_item(16'h05A5, 16'h0033);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_idle_pct = 16; recv_idle_pct = 52; end
				1: begin send_idle_pct = 52; recv_idle_pct = 16; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int chunk = 0; chunk < 9; chunk++) begin
				configure(pick_pitch(), 17'($urandom), 17'($urandom));
				repeat (48) send_item(pick_coord(), pick_coord());
			end
			if (ph == 0) begin
				// long receiver hold-off while the sender keeps offering
				drain_offsets();
				send_idle_pct = 0;
				stall_ask = 80;
				repeat (40) send_item(pick_coord(), pick_coord());
			end
		end

		drain_offsets();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_offsets.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
